// ===== design/rmq_pkg.sv =====
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;

  // compare shifts for the path terms against the threshold
  localparam int THR_SHIFT_TRACE = 14;
  localparam int THR_SHIFT_AXIS  = 15;

  typedef enum logic [1:0] {
    PATH_TRACE    = 2'd0,
    PATH_X        = 2'd1,
    PATH_Y        = 2'd2,
    PATH_FALLBACK = 2'd3
  } path_t;

endpackage

// ===== design/rmq_sqrt.sv =====
module rmq_sqrt #(
  parameter int RW = 48,
  parameter int PW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [RW-1:0]       in_rad,
  input  logic [PW-1:0]       in_pay,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RW/2-1:0]     out_root,
  output logic [PW-1:0]       out_pay
);

  localparam int N     = RW / 2;
  localparam int ROOTW = RW / 2;
  localparam int REMW  = ROOTW + 1;

  logic             v_r    [N];
  logic [RW-1:0]    rad_r  [N];
  logic [REMW-1:0]  rem_r  [N];
  logic [ROOTW-1:0] root_r [N];
  logic [PW-1:0]    pay_r  [N];
  logic             rdy    [N+1];

  assign rdy[N]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_pay   = pay_r[N-1];

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             v_i;
    logic [RW-1:0]    rad_i;
    logic [REMW-1:0]  rem_i;
    logic [ROOTW-1:0] root_i;
    logic [PW-1:0]    pay_i;
    logic [ROOTW+2:0] cur;
    logic [ROOTW+2:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign pay_i  = in_pay;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign pay_i  = pay_r[k-1];
    end

    assign cur    = {rem_i, rad_i[RW-1 -: 2]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign ge     = (cur >= trial);
    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_i) begin
        rad_r[k]  <= rad_i << 2;
        rem_r[k]  <= ge ? REMW'(cur - trial) : REMW'(cur);
        root_r[k] <= {root_i[ROOTW-2:0], ge};
        pay_r[k]  <= pay_i;
      end
    end
  end

endmodule

// ===== design/rmq_div.sv =====
module rmq_div #(
  parameter int NW = 31,
  parameter int DW = 26,
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0][NW-1:0]   in_num,
  input  logic [DW-1:0]        in_den,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0][NW-1:0]   out_quo,
  output logic [PW-1:0]        out_pay
);

  localparam int N = NW;

  logic            v_r   [N];
  logic [NW-1:0]   num_r [N][3];
  logic [DW-1:0]   rem_r [N][3];
  logic [NW-1:0]   quo_r [N][3];
  logic [DW-1:0]   den_r [N];
  logic [PW-1:0]   pay_r [N];
  logic            rdy   [N+1];

  assign rdy[N]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_pay   = pay_r[N-1];
  assign out_quo[0] = quo_r[N-1][0];
  assign out_quo[1] = quo_r[N-1][1];
  assign out_quo[2] = quo_r[N-1][2];

  // restoring division, one quotient bit per stage, three lanes share the divisor
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] den_i;
    logic [PW-1:0] pay_i;
    logic [NW-1:0] num_i [3];
    logic [DW-1:0] rem_i [3];
    logic [NW-1:0] quo_i [3];
    logic [DW-1:0] rem_n [3];
    logic          ge    [3];

    if (k == 0) begin : g_first
      always_comb begin
        v_i   = in_valid;
        den_i = in_den;
        pay_i = in_pay;
        for (int l = 0; l < 3; l++) begin
          num_i[l] = in_num[l];
          rem_i[l] = '0;
          quo_i[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_i   = v_r[k-1];
        den_i = den_r[k-1];
        pay_i = pay_r[k-1];
        for (int l = 0; l < 3; l++) begin
          num_i[l] = num_r[k-1][l];
          rem_i[l] = rem_r[k-1][l];
          quo_i[l] = quo_r[k-1][l];
        end
      end
    end

    always_comb begin
      logic [DW:0] cur;
      for (int l = 0; l < 3; l++) begin
        cur      = {rem_i[l], num_i[l][NW-1]};
        ge[l]    = (cur >= {1'b0, den_i});
        rem_n[l] = ge[l] ? DW'(cur - {1'b0, den_i}) : DW'(cur);
      end
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_i) begin
        den_r[k] <= den_i;
        pay_r[k] <= pay_i;
        for (int l = 0; l < 3; l++) begin
          num_r[k][l] <= num_i[l] << 1;
          rem_r[k][l] <= rem_n[l];
          quo_r[k][l] <= {quo_i[l][NW-2:0], ge[l]};
        end
      end
    end
  end

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion, signed fixed point with FRAC_BITS fraction bits.
// Input channel in_valid/in_ready carries the nine matrix entries in_m00..in_m22.
// Output channel out_valid/out_ready carries quat x/y/z/w, the path taken
// (trace, x, y, fixed fallback) and a flag set when a component was clipped.
// cfg_we/cfg_wdata write the threshold; write it only while the block is idle.
// The pipeline is one select stage, a square root pipeline of FRAC_BITS + 10
// stages (one root bit each), a divider pipeline of FRAC_BITS + 17 stages
// (one quotient bit each, three lanes sharing the divisor) and the
// clip/output register.
// Throughput is one request per cycle. Each stage has its own valid bit and
// loads whenever it is empty or the stage after it moves, so a stall on
// out_ready fills bubbles first and only then pushes back to in_ready.
// Nothing is dropped or repeated under stall.
// Reset (rst_n low, synchronous) empties the pipeline and clears the
// threshold to 0.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_m00,
  input  logic signed [15:0] in_m01,
  input  logic signed [15:0] in_m02,
  input  logic signed [15:0] in_m10,
  input  logic signed [15:0] in_m11,
  input  logic signed [15:0] in_m12,
  input  logic signed [15:0] in_m20,
  input  logic signed [15:0] in_m21,
  input  logic signed [15:0] in_m22,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic [1:0]         out_path_taken,
  output logic               out_saturated
);

  import rmq_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int SW    = F + 11;
  localparam int CW    = F + 34;
  localparam int RW    = 2 * F + 20;
  localparam int ROOTW = RW / 2;
  localparam int NW    = F + 17;
  localparam int DW    = ROOTW + 2;
  localparam int LIM   = (F >= 15) ? 32767 : (1 << F);
  localparam int PW1   = 2 + 3 + 3 * NW;
  localparam int PW2   = 2 + 3 + ROOTW;
  localparam logic [SW-1:0] ONE_S = SW'(64'd1 << F);
  localparam logic [15:0]   ONE_CLIP = 16'(LIM);
  localparam logic          ONE_SAT  = (F >= 15);

  logic [15:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // ---- select stage: pick path, form radicand and numerator magnitudes
  logic signed [SW-1:0] s, t, u;
  logic signed [CW-1:0] s_w, t_w, u_w, lim_w;
  logic                 take_s, take_t, take_u;
  path_t                path_nxt;
  logic [RW-1:0]        rad_nxt;
  logic signed [16:0]   d [3];
  logic [16:0]          dmag [3];
  logic [2:0][NW-1:0]   num_nxt;
  logic [2:0]           sign_nxt;

  always_comb begin
    s = $signed(ONE_S) + SW'(in_m00) + SW'(in_m11) + SW'(in_m22);
    t = -(SW'(in_m11) + SW'(in_m22));
    u = $signed(ONE_S) - SW'(in_m22);
    s_w   = CW'(s);
    t_w   = CW'(t);
    u_w   = CW'(u);
    lim_w = $signed(CW'(thr_r) << F);
    take_s = (s_w <<< THR_SHIFT_TRACE) > lim_w;
    take_t = (t_w <<< THR_SHIFT_AXIS) > lim_w;
    take_u = (u_w <<< THR_SHIFT_AXIS) > lim_w;

    priority if (take_s) begin
      path_nxt = PATH_TRACE;
      rad_nxt  = RW'(s[SW-2:0]) << (F - 2);
      d[0] = 17'(in_m21) - 17'(in_m12);
      d[1] = 17'(in_m02) - 17'(in_m20);
      d[2] = 17'(in_m10) - 17'(in_m01);
    end else if (take_t) begin
      path_nxt = PATH_X;
      rad_nxt  = RW'(t[SW-2:0]) << (F - 1);
      d[0] = '0;
      d[1] = 17'(in_m10);
      d[2] = 17'(in_m20);
    end else if (take_u) begin
      path_nxt = PATH_Y;
      rad_nxt  = RW'(u[SW-2:0]) << (F - 1);
      d[0] = '0;
      d[1] = '0;
      d[2] = 17'(in_m21);
    end else begin
      path_nxt = PATH_FALLBACK;
      rad_nxt  = '0;
      d[0] = '0;
      d[1] = '0;
      d[2] = '0;
    end

    for (int l = 0; l < 3; l++) begin
      sign_nxt[l] = d[l][16];
      dmag[l]     = d[l][16] ? 17'(-d[l]) : 17'(d[l]);
      num_nxt[l]  = NW'(dmag[l]) << F;
    end
  end

  logic               fv_r;
  logic               f_rdy;
  path_t              f_path_r;
  logic [RW-1:0]      f_rad_r;
  logic [2:0][NW-1:0] f_num_r;
  logic [2:0]         f_sign_r;
  logic               sq_in_ready;

  assign f_rdy    = !fv_r || sq_in_ready;
  assign in_ready = f_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (f_rdy) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy && in_valid) begin
      f_path_r <= path_nxt;
      f_rad_r  <= rad_nxt;
      f_num_r  <= num_nxt;
      f_sign_r <= sign_nxt;
    end
  end

  // ---- square root
  logic             sq_out_valid;
  logic             sq_out_ready;
  logic [ROOTW-1:0] sq_root;
  logic [PW1-1:0]   sq_pay;

  rmq_sqrt #(
    .RW (RW),
    .PW (PW1)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv_r),
    .in_ready  (sq_in_ready),
    .in_rad    (f_rad_r),
    .in_pay    ({f_path_r, f_sign_r, f_num_r}),
    .out_valid (sq_out_valid),
    .out_ready (sq_out_ready),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  path_t              sq_path;
  logic [2:0]         sq_sign;
  logic [2:0][NW-1:0] sq_num;
  logic [DW-1:0]      den;

  assign sq_path = path_t'(sq_pay[PW1-1 -: 2]);
  assign sq_sign = sq_pay[PW1-3 -: 3];
  assign sq_num  = sq_pay[3*NW-1:0];
  // trace path divides by 4w, axis paths by twice the root
  assign den = (sq_path == PATH_TRACE) ? {sq_root, 2'b00} : {1'b0, sq_root, 1'b0};

  // ---- divider
  logic               dv_out_valid;
  logic               dv_out_ready;
  logic [2:0][NW-1:0] dv_quo;
  logic [PW2-1:0]     dv_pay;

  rmq_div #(
    .NW (NW),
    .DW (DW),
    .PW (PW2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_out_valid),
    .in_ready  (sq_out_ready),
    .in_num    (sq_num),
    .in_den    (den),
    .in_pay    ({sq_path, sq_sign, sq_root}),
    .out_valid (dv_out_valid),
    .out_ready (dv_out_ready),
    .out_quo   (dv_quo),
    .out_pay   (dv_pay)
  );

  // ---- clip and output register
  path_t              dv_path;
  logic [2:0]         dv_sign;
  logic [ROOTW-1:0]   dv_root;
  logic signed [15:0] qv [3];
  logic [2:0]         qbig;
  logic               rbig;
  logic signed [15:0] rv;
  logic [15:0]        cm;
  logic signed [15:0] x_nxt, y_nxt, z_nxt, w_nxt;
  logic               sat_nxt;

  assign dv_path = path_t'(dv_pay[PW2-1 -: 2]);
  assign dv_sign = dv_pay[PW2-3 -: 3];
  assign dv_root = dv_pay[ROOTW-1:0];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qbig[l] = dv_quo[l] > NW'(LIM);
      cm      = qbig[l] ? 16'(LIM) : dv_quo[l][15:0];
      qv[l]   = dv_sign[l] ? $signed(-cm) : $signed(cm);
    end
    rbig = dv_root > ROOTW'(LIM);
    rv   = rbig ? $signed(16'(LIM)) : $signed(dv_root[15:0]);

    unique case (dv_path)
      PATH_TRACE: begin
        x_nxt = qv[0];
        y_nxt = qv[1];
        z_nxt = qv[2];
        w_nxt = rv;
        sat_nxt = |qbig || rbig;
      end
      PATH_X: begin
        x_nxt = rv;
        y_nxt = qv[1];
        z_nxt = qv[2];
        w_nxt = '0;
        sat_nxt = qbig[1] || qbig[2] || rbig;
      end
      PATH_Y: begin
        x_nxt = '0;
        y_nxt = rv;
        z_nxt = qv[2];
        w_nxt = '0;
        sat_nxt = qbig[2] || rbig;
      end
      PATH_FALLBACK: begin
        x_nxt = '0;
        y_nxt = '0;
        z_nxt = $signed(ONE_CLIP);
        w_nxt = '0;
        sat_nxt = ONE_SAT;
      end
      default: begin
        x_nxt = '0;
        y_nxt = '0;
        z_nxt = '0;
        w_nxt = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  logic               out_valid_r;
  logic signed [15:0] x_r, y_r, z_r, w_r;
  logic [1:0]         path_r;
  logic               sat_r;

  assign dv_out_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_out_ready) begin
      out_valid_r <= dv_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_out_ready && dv_out_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      w_r    <= w_nxt;
      path_r <= dv_path;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_x     = x_r;
  assign out_quat_y     = y_r;
  assign out_quat_z     = z_r;
  assign out_quat_w     = w_r;
  assign out_path_taken = path_r;
  assign out_saturated  = sat_r;

endmodule

// ===== design/rmq_chk.sv =====
module rmq_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_quat_x,
  input logic signed [15:0] out_quat_y,
  input logic signed [15:0] out_quat_w,
  input logic [1:0]         out_path_taken
);

  import rmq_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_x) && $stable(out_path_taken))
    else $error("stalled output changed");

  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_taken == PATH_FALLBACK |->
      out_quat_x == 16'sd0 && out_quat_y == 16'sd0 && out_quat_w == 16'sd0)
    else $error("fallback result has nonzero x, y or w");

  a_x_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_taken == PATH_X |-> out_quat_w == 16'sd0)
    else $error("x path result has nonzero w");

  a_y_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_taken == PATH_Y |-> out_quat_x == 16'sd0 && out_quat_w == 16'sd0)
    else $error("y path result has nonzero x or w");

endmodule

bind rotation_matrix_to_quaternion rmq_chk u_rmq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_quat_x     (out_quat_x),
  .out_quat_y     (out_quat_y),
  .out_quat_w     (out_quat_w),
  .out_path_taken (out_path_taken)
);
